/* rtl/cfq_pkg.sv */
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

    localparam int DATA_W        = 32;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_RESET     = 16;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic [CAP_W-1:0]         count;
        logic                     is_empty;
        logic                     is_full;
    } cfq_result_t;

endpackage

/* rtl/cfq_ram.sv */
// Word storage for the queue: one write port and one registered read port.
module cfq_ram #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic signed [cfq_pkg::DATA_W-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [AW-1:0]                   rd_addr,
    output logic signed [cfq_pkg::DATA_W-1:0] rd_data
);
    import cfq_pkg::*;

    logic signed [DATA_W-1:0] slot_mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/circular_fifo_queue.sv */
// Top level of the circular FIFO queue: command decode, pointers and result staging.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------------
//  in       | sink      | in_valid / in_stall    | command, value
//  out      | source    | out_valid / out_stall  | data, status, count, is_empty, is_full
//  cfg      | sink      | cfg_valid / cfg_ready  | cfg_capacity
//
// A request is handled in the cycle it is accepted, in which the pointers and count are
// updated and the storage is written or read, and when the registered read data of the
// storage comes back; with its single read port, in_stall holds off requests until then.
// Results leave from an output register, with one holding register behind it, so a
// request is taken while an earlier result still waits on out_stall.
// Reset empties the queue and sets the capacity to 16; the storage itself is not cleared.
module circular_fifo_queue #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic signed [cfq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cfq_pkg::DATA_W-1:0] data,
    output logic [1:0]                        status,
    output logic [cfq_pkg::CAP_W-1:0]         count,
    output logic                              is_empty,
    output logic                              is_full,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfq_pkg::CAP_W-1:0]         cfg_capacity
);
    import cfq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (AW > CAP_W) ? AW : CAP_W;
    localparam int CAP_LIMIT = (1 << CAP_W) - 1;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'((DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT);

    // Control state
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic             rd_wait_reg, rd_wait_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Result staging
    cfq_result_t      stage_reg, stage_next;
    logic             stage_rd_reg, stage_rd_next;
    cfq_result_t      pend_reg, pend_next;
    cfq_result_t      out_reg, out_next;

    logic [CAP_W-1:0] cap_eff;
    logic             in_accept;
    logic             cfg_write;
    logic             out_free;
    logic             mem_wr;
    logic             mem_rd;
    logic signed [DATA_W-1:0] mem_rdata;
    cfq_result_t      stage_res;
    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    tail_inc;
    logic [AW-1:0]    head_adv;
    logic [AW-1:0]    tail_adv;

    assign cap_eff = (cap_reg == '0) ? CAP_W'(1)
                   : ((cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);

    assign in_stall  = rd_wait_reg | pend_valid_reg;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign out_free  = ~out_valid_reg | ~out_stall;

    // Pointers wrap at the effective capacity, not at the storage depth.
    assign head_inc = IW'(head_reg) + IW'(1);
    assign tail_inc = IW'(tail_reg) + IW'(1);
    assign head_adv = (head_inc >= IW'(cap_eff)) ? '0 : AW'(head_inc);
    assign tail_adv = (tail_inc >= IW'(cap_eff)) ? '0 : AW'(tail_inc);

    // A read is issued only by a request accepted after every earlier write is stored, as
    // in_stall holds off requests while read data returns, so no forwarding is needed.
    cfq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (tail_reg),
        .wr_data (value),
        .rd_en   (mem_rd),
        .rd_addr (head_reg),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        stage_next    = stage_reg;
        stage_rd_next = 1'b0;
        rd_wait_next  = in_accept;
        mem_wr        = 1'b0;
        mem_rd        = 1'b0;

        if (cfg_write)
        begin
            cap_next   = cfg_capacity;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (in_accept)
        begin
            stage_next.data   = '0;
            stage_next.status = ST_OK;
            case (cmd_t'(command))
                CMD_ENQUEUE:
                begin
                    if (count_reg >= cap_eff)
                    begin
                        stage_next.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_wr     = 1'b1;
                        tail_next  = tail_adv;
                        count_next = count_reg + CAP_W'(1);
                    end
                end
                CMD_DEQUEUE, CMD_PEEK:
                begin
                    if (count_reg == '0)
                    begin
                        stage_next.data   = '1;
                        stage_next.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        mem_rd        = 1'b1;
                        stage_rd_next = 1'b1;
                        if (cmd_t'(command) == CMD_DEQUEUE)
                        begin
                            head_next  = head_adv;
                            count_next = count_reg - CAP_W'(1);
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
            stage_next.count    = count_next;
            stage_next.is_empty = (count_next == '0);
            stage_next.is_full  = (count_next == cap_eff);
        end
    end

    // The read data is merged into the result in the cycle after acceptance.
    always_comb
    begin
        stage_res = stage_reg;
        if (stage_rd_reg)
        begin
            stage_res.data = mem_rdata;
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        if (out_free)
        begin
            out_valid_next = rd_wait_reg | pend_valid_reg;
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (rd_wait_reg)
            begin
                out_next = stage_res;
            end
        end
        else if (rd_wait_reg)
        begin
            pend_next       = stage_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_W'(CAP_RESET);
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            rd_wait_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            stage_rd_reg   <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            rd_wait_reg    <= rd_wait_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            stage_rd_reg   <= stage_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = out_reg.data;
    assign status    = out_reg.status;
    assign count     = out_reg.count;
    assign is_empty  = out_reg.is_empty;
    assign is_full   = out_reg.is_full;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> rd_wait_reg)
        else $error("accepted request did not reach the read cycle");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_wait_reg && pend_valid_reg))
        else $error("read cycle overlaps a held result");

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("held result without a result in the output register");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_eff)
        else $error("stored count exceeds capacity");
`endif

endmodule

/* verif/circular_fifo_queue_test.sv */
// Self-checking testbench for the circular FIFO queue, with a scoreboard class and random requests.
module circular_fifo_queue_test;

    import cfq_pkg::*;

    // Mirrors the ring buffer and keeps the results that the block still owes.
    class fifo_predictor;
        bit [CAP_W-1:0]           capacity;
        logic signed [DATA_W-1:0] slots [DEPTH_DEFAULT];
        int                       head;
        int                       tail;
        int                       stored;
        cfq_result_t              awaited [$];
        int                       errors;
        int                       requests;
        int                       overflows;
        int                       underflows;
        int                       clears;

        function void reset_state();
            capacity = CAP_W'(CAP_RESET);
            head     = 0;
            tail     = 0;
            stored   = 0;
            awaited.delete();
        endfunction

        // A capacity write always leaves the queue empty.
        function void set_capacity(bit [CAP_W-1:0] v);
            capacity = v;
            head     = 0;
            tail     = 0;
            stored   = 0;
        endfunction

        function int slot_limit();
            int c;
            c = int'(capacity);
            if (c < 1)
                c = 1;
            if (c > DEPTH_DEFAULT)
                c = DEPTH_DEFAULT;
            return c;
        endfunction

        function void note_request(cmd_t cmd, logic signed [DATA_W-1:0] val);
            cfq_result_t r;
            int          c;
            c        = slot_limit();
            r.data   = '0;
            r.status = ST_OK;
            requests++;
            case (cmd)
                CMD_ENQUEUE:
                begin
                    if (stored >= c)
                    begin
                        r.status = ST_OVERFLOW;
                        overflows++;
                    end
                    else
                    begin
                        slots[tail] = val;
                        tail        = (tail + 1 >= c) ? 0 : tail + 1;
                        stored++;
                    end
                end
                CMD_DEQUEUE, CMD_PEEK:
                begin
                    if (stored == 0)
                    begin
                        r.data   = -1;
                        r.status = ST_UNDERFLOW;
                        underflows++;
                    end
                    else
                    begin
                        r.data = slots[head];
                        if (cmd == CMD_DEQUEUE)
                        begin
                            head = (head + 1 >= c) ? 0 : head + 1;
                            stored--;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    head   = 0;
                    tail   = 0;
                    stored = 0;
                    clears++;
                end
            endcase
            r.count    = CAP_W'(stored);
            r.is_empty = (stored == 0);
            r.is_full  = (stored == c);
            awaited.push_back(r);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] d, logic [1:0] s,
                                   logic [CAP_W-1:0] n, logic e, logic f);
            cfq_result_t x;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: data %0d status %0d count %0d", d, s, n);
                errors++;
                return;
            end
            x = awaited.pop_front();
            if (d !== x.data)
            begin
                $error("data: expected %0d, actual %0d", x.data, d);
                errors++;
            end
            if (s !== x.status)
            begin
                $error("status: expected %0d, actual %0d", x.status, s);
                errors++;
            end
            if (n !== x.count)
            begin
                $error("count: expected %0d, actual %0d", x.count, n);
                errors++;
            end
            if (e !== x.is_empty)
            begin
                $error("is_empty: expected %0b, actual %0b", x.is_empty, e);
                errors++;
            end
            if (f !== x.is_full)
            begin
                $error("is_full: expected %0b, actual %0b", x.is_full, f);
                errors++;
            end
        endfunction
    endclass

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic [1:0]               command      = CMD_ENQUEUE;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [CAP_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_capacity = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int settings_used = 1;

    fifo_predictor model = new;

    circular_fifo_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data         (data),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    always #5 clk = ~clk;

    // Handshakes are sampled at the edge, before any register of this step has moved.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                model.note_request(cmd_t'(command), value);
            if (out_valid && !out_stall)
                model.check_result(data, status, count, is_empty, is_full);
        end
    end

    // Receiver: random stalls, or a long hold-off counted here whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = 60;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(cmd_t cmd, logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (model.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(bit [CAP_W-1:0] v);
        cfg_valid    <= 1'b1;
        cfg_capacity <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model.set_capacity(v);
        cfg_valid <= 1'b0;
        settings_used++;
        repeat (2) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_t pick_command(int enqueue_pct);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return CMD_CLEAR;
        if (r < 4 + enqueue_pct)
            return CMD_ENQUEUE;
        if ($urandom_range(2) == 0)
            return CMD_PEEK;
        return CMD_DEQUEUE;
    endfunction

    initial
    begin
        bit [CAP_W-1:0] cap;
        int             enqueue_pct;

        model.reset_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: underflow on an empty queue, extreme words, clear.
        send_request(CMD_DEQUEUE, 0);
        send_request(CMD_PEEK, 0);
        send_request(CMD_ENQUEUE, 32'sh8000_0000);
        send_request(CMD_ENQUEUE, 32'sh7FFF_FFFF);
        send_request(CMD_ENQUEUE, -1);
        send_request(CMD_ENQUEUE, 0);
        send_request(CMD_PEEK, 0);
        send_request(CMD_DEQUEUE, 0);
        send_request(CMD_DEQUEUE, 0);
        send_request(CMD_CLEAR, 32'sh5555_AAAA);
        send_request(CMD_DEQUEUE, 0);
        drain_results();

        // A capacity of zero behaves as a single slot.
        write_capacity(0);
        send_request(CMD_ENQUEUE, 32'sh1234_5678);
        send_request(CMD_ENQUEUE, 32'shCAFE_0001);
        send_request(CMD_PEEK, 0);
        send_request(CMD_DEQUEUE, 0);
        send_request(CMD_PEEK, 0);
        drain_results();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:       cap = CAP_W'(31);
                1:       cap = CAP_W'(1);
                2:       cap = CAP_W'(16);
                4:       cap = CAP_W'($urandom_range(17, 30));
                5:       cap = CAP_W'(0);
                default: cap = CAP_W'($urandom_range(2, 15));
            endcase
            write_capacity(cap);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 61;
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct     = 37;
                end
            endcase
            enqueue_pct = (p % 2 == 0) ? 62 : 40;
            for (int i = 0; i < 70; i++)
            begin
                // The receiver goes quiet while requests keep coming, so the block backs up.
                if (p == 0 && i == 25)
                    hold_requests++;
                if (p == 2 && i == 35)
                    drain_results();
                send_request(pick_command(enqueue_pct), pick_word());
            end
            drain_results();
            send_idle_pct = 0;
            stall_pct     = 0;
        end

        $display("Run covered %0d requests over %0d capacity settings,",
                 model.requests, settings_used);
        $display("with back-pressure phases: %0d overflows, %0d underflows and %0d clears.",
                 model.overflows, model.underflows, model.clears);
        if (model.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
